/* hdl/switch_buffer_credit_accounting_defines.svh */
// ---------------------------------------------------------------------------
// Switch buffer credit accounting: assertion macros
// Shared assertion forms, clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SWITCH_BUFFER_CREDIT_ACCOUNTING_DEFINES_SVH
`define SWITCH_BUFFER_CREDIT_ACCOUNTING_DEFINES_SVH

// same-cycle implication
`define SBCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SBCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sbca_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbca_pkg
// Types, codes and defaults for the switch buffer credit accounting block.
// ---------------------------------------------------------------------------
package sbca_pkg;

    localparam int PORT_COUNT_DEF  = 16;
    localparam int QUEUE_COUNT_DEF = 8;

    localparam int CNT_W  = 32;
    localparam int PROB_W = 17;
    localparam int RND_W  = 16;
    localparam int SIZE_W = 16;
    localparam int LHS_W  = RND_W + CNT_W;
    localparam int RHS_W  = PROB_W + CNT_W;

    typedef enum logic [2:0] {
        OP_ADMIT     = 3'd0,
        OP_ING_ADD   = 3'd1,
        OP_EGR_ADD   = 3'd2,
        OP_ING_REM   = 3'd3,
        OP_EGR_REM   = 3'd4,
        OP_REPORT    = 3'd5,
        OP_MARK      = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        REG_PORT_BUF  = 2'd0,
        REG_MARK_LOW  = 2'd1,
        REG_MARK_HIGH = 2'd2,
        REG_PROB_MAX  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]        operation;
        logic [3:0]        port;
        logic [2:0]        queue;
        logic [SIZE_W-1:0] packet_bytes;
        logic [RND_W-1:0]  random_fraction;
    } t_item;

    typedef struct packed {
        logic             admit;
        logic             mark;
        logic [CNT_W-1:0] credit_limit;
        logic [CNT_W-1:0] queue_length;
        logic [CNT_W-1:0] drained_credit;
        logic [CNT_W-1:0] used_credit;
    } t_result;

    typedef struct packed {
        logic              q_zero;
        logic              gt_high;
        logic              gt_low;
        logic [CNT_W-1:0]  span;
        logic [CNT_W-1:0]  over;
        logic [RND_W-1:0]  rnd;
        logic [PROB_W-1:0] prob;
    } t_mark_req;

    typedef struct packed {
        logic [CNT_W-1:0] ingress;
        logic [CNT_W-1:0] egress;
        logic [CNT_W-1:0] drained;
        logic [CNT_W-1:0] sent;
    } t_queue_entry;

    typedef struct packed {
        logic [CNT_W-1:0] admitted;
        logic [CNT_W-1:0] used;
    } t_port_entry;

    function automatic logic [CNT_W-1:0] floor_sub(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        return (a >= b) ? (a - b) : '0;
    endfunction

endpackage

/* hdl/sbca_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbca_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sbca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/sbca_mark.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbca_mark
// Congestion mark decision: registered products, then threshold compare.
// ---------------------------------------------------------------------------
module sbca_mark import sbca_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_mark_req i_req,
    output logic      o_mark
);

    logic [LHS_W-1:0] r_lhs;
    logic [RHS_W-1:0] r_rhs;
    logic             r_q_zero;
    logic             r_gt_high;
    logic             r_gt_low;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lhs     <= LHS_W'(i_req.rnd) * LHS_W'(i_req.span);
            r_rhs     <= RHS_W'(i_req.prob) * RHS_W'(i_req.over);
            r_q_zero  <= i_req.q_zero;
            r_gt_high <= i_req.gt_high;
            r_gt_low  <= i_req.gt_low;
        end
    end

    assign o_mark = !r_q_zero && (r_gt_high || (r_gt_low && (RHS_W'(r_lhs) < r_rhs)));

endmodule

/* hdl/switch_buffer_credit_accounting.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// switch_buffer_credit_accounting
// Per-port and per-queue byte accounting with RED-style congestion marking.
// ---------------------------------------------------------------------------
// Usage:
//   Command beat: drive i_item and raise i_start; the beat is taken at an edge
//   where o_busy is low. Exactly one result beat follows on o_result, marked
//   by o_valid for a single cycle; the receiver cannot stall it.
//   The accepted command runs in S_EXEC (read-modify-write of the counter
//   RAMs, result registered); a congestion check goes on through S_MUL
//   (registered products) and S_CMP (threshold compare). One command is in
//   flight at a time: o_busy is high until its result beat is registered.
//   Configuration: i_cfg_we, i_cfg_idx, i_cfg_wdata write one register per
//   cycle, at any time including the clearing pass; write only when idle.
//   Reset: synchronous, active low. After reset the counter RAMs are zeroed
//   by a clearing pass over all PORT_COUNT*QUEUE_COUNT queue entries, during
//   which o_busy is high and no command is taken.
//   Out-of-range port or queue and unknown operations return all-zero results.
// ---------------------------------------------------------------------------
module switch_buffer_credit_accounting import sbca_pkg::*; #(
    parameter int PORT_COUNT  = PORT_COUNT_DEF,
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_item       i_item,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    `include "switch_buffer_credit_accounting_defines.svh"

    localparam int QDEPTH = PORT_COUNT * QUEUE_COUNT;
    localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int PA_W   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam logic [QA_W-1:0] CLR_LAST = QA_W'(QDEPTH - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_MUL   = 5'b01000,
        S_CMP   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [QA_W-1:0]    r_clr, n_clr;
    logic               r_valid, n_valid;
    t_result            r_result, n_result;
    t_item              r_item, n_item;
    logic [QA_W-1:0]    r_qaddr, n_qaddr;
    logic [PA_W-1:0]    r_paddr, n_paddr;
    logic               r_in_range, n_in_range;
    t_mark_req          r_mreq, n_mreq;

    logic [CNT_W-1:0]   r_port_buf;
    logic [CNT_W-1:0]   r_mark_low;
    logic [CNT_W-1:0]   r_mark_high;
    logic [PROB_W-1:0]  r_prob_max;

    logic               w_accept;
    logic [QA_W-1:0]    w_rd_qaddr;
    logic [PA_W-1:0]    w_rd_paddr;
    t_queue_entry       w_q_rd, w_q_new, w_q_wdata;
    t_port_entry        w_p_rd, w_p_new, w_p_wdata;
    logic               w_q_wr, w_p_wr;
    logic               w_q_we, w_p_we;
    logic [QA_W-1:0]    w_q_waddr;
    logic [PA_W-1:0]    w_p_waddr;
    t_result            w_res;
    t_mark_req          w_mreq;
    logic               w_mark;
    logic [CNT_W-1:0]   w_size;

    assign o_busy     = (r_state != S_IDLE);
    assign w_accept   = i_start && !o_busy;
    assign w_rd_qaddr = QA_W'(int'(i_item.port) * QUEUE_COUNT + int'(i_item.queue));
    assign w_rd_paddr = PA_W'(i_item.port);

    // counter RAMs
    sbca_ram #(
        .WIDTH ($bits(t_queue_entry)),
        .DEPTH (QDEPTH),
        .AW    (QA_W)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_raddr (w_rd_qaddr),
        .o_rdata (w_q_rd)
    );

    sbca_ram #(
        .WIDTH ($bits(t_port_entry)),
        .DEPTH (PORT_COUNT),
        .AW    (PA_W)
    ) u_port_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_p_wdata),
        .i_raddr (w_rd_paddr),
        .o_rdata (w_p_rd)
    );

    sbca_mark u_mark (
        .i_clk  (i_clk),
        .i_en   (r_state == S_MUL),
        .i_req  (r_mreq),
        .o_mark (w_mark)
    );

    // read-modify-write of the addressed entries
    always_comb begin
        w_size  = CNT_W'(r_item.packet_bytes);
        w_q_new = w_q_rd;
        w_p_new = w_p_rd;
        w_q_wr  = 1'b0;
        w_p_wr  = 1'b0;
        w_res   = '0;
        case (r_item.operation)
            OP_ADMIT: begin
                w_res.admit = (w_p_rd.used <= r_port_buf) &&
                              ((r_port_buf - w_p_rd.used) >= w_size);
            end
            OP_ING_ADD: begin
                w_p_new.admitted = w_p_rd.admitted + w_size;
                w_p_new.used     = w_p_rd.used + w_size;
                w_q_new.ingress  = w_q_rd.ingress + w_size;
                w_q_wr           = 1'b1;
                w_p_wr           = 1'b1;
            end
            OP_EGR_ADD: begin
                w_q_new.egress = w_q_rd.egress + w_size;
                w_q_wr         = 1'b1;
            end
            OP_ING_REM: begin
                w_q_new.ingress = floor_sub(w_q_rd.ingress, w_size);
                w_q_new.drained = w_q_rd.drained + w_size;
                w_p_new.used    = floor_sub(w_p_rd.used, w_size);
                w_q_wr          = 1'b1;
                w_p_wr          = 1'b1;
            end
            OP_EGR_REM: begin
                w_q_new.sent   = w_q_rd.sent + w_size;
                w_q_new.egress = floor_sub(w_q_rd.egress, w_size);
                w_q_wr         = 1'b1;
            end
            OP_REPORT: begin
                w_res.credit_limit   = w_p_rd.admitted + (r_port_buf - w_p_rd.used);
                w_res.queue_length   = w_q_rd.ingress;
                w_res.drained_credit = w_q_rd.drained;
                w_res.used_credit    = w_q_rd.sent;
            end
            default: begin
            end
        endcase
        if (!r_in_range) begin
            w_res  = '0;
            w_q_wr = 1'b0;
            w_p_wr = 1'b0;
        end

        w_mreq.q_zero  = (r_item.queue == '0);
        w_mreq.gt_high = (w_q_rd.egress > r_mark_high);
        w_mreq.gt_low  = (w_q_rd.egress > r_mark_low);
        w_mreq.span    = r_mark_high - r_mark_low;
        w_mreq.over    = w_q_rd.egress - r_mark_low;
        w_mreq.rnd     = r_item.random_fraction;
        w_mreq.prob    = r_prob_max;
    end

    // write port: clearing pass or write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_q_we    = 1'b1;
            w_q_waddr = r_clr;
            w_q_wdata = '0;
            w_p_we    = (32'(r_clr) < 32'(PORT_COUNT));
            w_p_waddr = r_clr[PA_W-1:0];
            w_p_wdata = '0;
        end else begin
            w_q_we    = (r_state == S_EXEC) && w_q_wr;
            w_q_waddr = r_qaddr;
            w_q_wdata = w_q_new;
            w_p_we    = (r_state == S_EXEC) && w_p_wr;
            w_p_waddr = r_paddr;
            w_p_wdata = w_p_new;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_valid    = 1'b0;
        n_result   = r_result;
        n_item     = r_item;
        n_qaddr    = r_qaddr;
        n_paddr    = r_paddr;
        n_in_range = r_in_range;
        n_mreq     = r_mreq;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + QA_W'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_item     = i_item;
                    n_qaddr    = w_rd_qaddr;
                    n_paddr    = w_rd_paddr;
                    n_in_range = (32'(i_item.port) < 32'(PORT_COUNT)) &&
                                 (32'(i_item.queue) < 32'(QUEUE_COUNT));
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_result = w_res;
                n_mreq   = w_mreq;
                if (r_in_range && (r_item.operation == OP_MARK)) begin
                    n_state = S_MUL;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_result      = '0;
                n_result.mark = w_mark;
                n_valid       = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result   <= n_result;
        r_item     <= n_item;
        r_qaddr    <= n_qaddr;
        r_paddr    <= n_paddr;
        r_in_range <= n_in_range;
        r_mreq     <= n_mreq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_buf  <= '0;
            r_mark_low  <= '0;
            r_mark_high <= '0;
            r_prob_max  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PORT_BUF:  r_port_buf  <= i_cfg_wdata;
                REG_MARK_LOW:  r_mark_low  <= i_cfg_wdata;
                REG_MARK_HIGH: r_mark_high <= i_cfg_wdata;
                REG_PROB_MAX:  r_prob_max  <= i_cfg_wdata[PROB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `SBCA_ASSERT_NEXT(a_accept_exec, w_accept, r_state == S_EXEC, "accepted beat not executed")
    `SBCA_ASSERT_SAME(a_valid_src, o_valid, $past(r_state) == S_EXEC || $past(r_state) == S_CMP, "result beat without source")
    `SBCA_ASSERT_SAME(a_no_idle_write, !o_busy, !w_q_we && !w_p_we, "RAM write while idle")
    `SBCA_ASSERT_NEXT(a_mark_path, r_state == S_MUL, r_state == S_CMP && !o_valid, "mark path broken")

endmodule

/* dv/switch_buffer_credit_accounting_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// switch_buffer_credit_accounting_tb
// Self-checking bench for the switch buffer accounting block. A ledger class
// mirrors the per-port and per-queue byte counters and the marking rule,
// works out the result of every accepted command and compares it with the
// result beat. A directed pass covers the corner cases. Random phases then
// run under several register settings, with random gaps on the command side.
// ---------------------------------------------------------------------------
module switch_buffer_credit_accounting_tb;
    import sbca_pkg::*;

    localparam int         PORTS       = PORT_COUNT_DEF;
    localparam int         QUEUES      = QUEUE_COUNT_DEF;
    localparam int         ENTRIES     = PORTS * QUEUES;
    localparam logic [2:0] OP_UNUSED   = 3'd7;
    localparam int         PHASE_BEATS = 300;
    localparam int         STALL_LIMIT = 1000;
    localparam int         DRAIN_WAIT  = 8;

    class credit_ledger;
        bit [31:0]  port_buf;
        bit [31:0]  mark_low;
        bit [31:0]  mark_high;
        bit [16:0]  prob_max;
        bit [31:0]  ing_bytes [ENTRIES];
        bit [31:0]  egr_bytes [ENTRIES];
        bit [31:0]  drained [ENTRIES];
        bit [31:0]  sent [ENTRIES];
        bit [31:0]  admitted [PORTS];
        bit [31:0]  port_used [PORTS];
        bit [31:0]  port_sent [PORTS];
        bit [63:0]  pool_used;
        t_result    pending_results [$];
        int         errors;

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_PORT_BUF:  port_buf  = data;
                REG_MARK_LOW:  mark_low  = data;
                REG_MARK_HIGH: mark_high = data;
                REG_PROB_MAX:  prob_max  = data[16:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] floor_diff(bit [31:0] a, bit [31:0] b);
            return (a >= b) ? a - b : 32'd0;
        endfunction

        function bit congestion(bit [31:0] egr, bit [2:0] q, bit [15:0] rnd);
            bit [31:0] span;
            bit [31:0] over;
            bit [63:0] lhs;
            bit [63:0] rhs;
            if (q == 0) return 1'b0;
            if (egr > mark_high) return 1'b1;
            if (egr <= mark_low) return 1'b0;
            span = mark_high - mark_low;
            over = egr - mark_low;
            lhs  = 64'(rnd) * 64'(span);
            rhs  = 64'(prob_max) * 64'(over);
            return lhs < rhs;
        endfunction

        function void account_command(t_item it);
            t_result   r;
            int        k;
            bit [31:0] used;
            bit [31:0] sz;
            r = '0;
            if (it.port < PORTS && it.queue < QUEUES) begin
                k    = it.port * QUEUES + it.queue;
                sz   = 32'(it.packet_bytes);
                used = port_used[it.port];
                case (it.operation)
                    OP_ADMIT: r.admit = (used <= port_buf) && (port_buf - used >= sz);
                    OP_ING_ADD: begin
                        admitted[it.port]  = admitted[it.port] + sz;
                        ing_bytes[k]       = ing_bytes[k] + sz;
                        pool_used          = pool_used + 64'(sz);
                        port_used[it.port] = used + sz;
                    end
                    OP_EGR_ADD: egr_bytes[k] = egr_bytes[k] + sz;
                    OP_ING_REM: begin
                        ing_bytes[k]       = floor_diff(ing_bytes[k], sz);
                        pool_used          = (pool_used >= 64'(sz)) ?
                                             pool_used - 64'(sz) : 64'd0;
                        port_used[it.port] = floor_diff(used, sz);
                        drained[k]         = drained[k] + sz;
                    end
                    OP_EGR_REM: begin
                        port_sent[it.port] = port_sent[it.port] + sz;
                        sent[k]            = sent[k] + sz;
                        egr_bytes[k]       = floor_diff(egr_bytes[k], sz);
                    end
                    OP_REPORT: begin
                        r.credit_limit   = admitted[it.port] + (port_buf - used);
                        r.queue_length   = ing_bytes[k];
                        r.drained_credit = drained[k];
                        r.used_credit    = sent[k];
                    end
                    OP_MARK: r.mark = congestion(egr_bytes[k], it.queue, it.random_fraction);
                    default: ;
                endcase
            end
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 100)
                $display("%0t ns: mismatch on %s: got %0h, expected %0h",
                         $time, what, got, want);
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("unexpected result beat", got.credit_limit, 32'd0);
                return;
            end
            want = pending_results.pop_front();
            if (got.admit !== want.admit) report("admit", 32'(got.admit), 32'(want.admit));
            if (got.mark !== want.mark) report("mark", 32'(got.mark), 32'(want.mark));
            if (got.credit_limit !== want.credit_limit)
                report("credit_limit", got.credit_limit, want.credit_limit);
            if (got.queue_length !== want.queue_length)
                report("queue_length", got.queue_length, want.queue_length);
            if (got.drained_credit !== want.drained_credit)
                report("drained_credit", got.drained_credit, want.drained_credit);
            if (got.used_credit !== want.used_credit)
                report("used_credit", got.used_credit, want.used_credit);
        endtask

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_start     = 1'b0;
    t_item       i_item      = '0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        o_busy;
    logic        o_valid;
    t_result     o_result;

    credit_ledger ledger = new();
    int           stall_cycles = 0;

    switch_buffer_credit_accounting u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) ledger.write_reg(i_cfg_idx, i_cfg_wdata);
            if (o_valid) ledger.check_result(o_result);
            if (i_start && !o_busy) ledger.account_command(i_item);
            if (o_valid || (i_start && !o_busy)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("** switch_buffer_credit_accounting: FAILED **");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic issue_command(t_item it, int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic issue_fields(logic [2:0] op, logic [3:0] port, logic [2:0] queue,
                                logic [15:0] size, logic [15:0] rnd);
        t_item it;
        it.operation       = op;
        it.port            = port;
        it.queue           = queue;
        it.packet_bytes    = size;
        it.random_fraction = rnd;
        issue_command(it, $urandom_range(0, 13));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [31:0] buf_bytes, logic [31:0] low, logic [31:0] high,
                              logic [31:0] prob);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_PORT_BUF;
        i_cfg_wdata <= buf_bytes;
        @(negedge i_clk);
        i_cfg_idx   <= REG_MARK_LOW;
        i_cfg_wdata <= low;
        @(negedge i_clk);
        i_cfg_idx   <= REG_MARK_HIGH;
        i_cfg_wdata <= high;
        @(negedge i_clk);
        i_cfg_idx   <= REG_PROB_MAX;
        i_cfg_wdata <= prob;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // most traffic on a few ports so counters climb past the thresholds
    function automatic t_item packet_event();
        t_item it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)      it.operation = OP_ADMIT;
        else if (pick < 35) it.operation = OP_ING_ADD;
        else if (pick < 50) it.operation = OP_EGR_ADD;
        else if (pick < 63) it.operation = OP_ING_REM;
        else if (pick < 75) it.operation = OP_EGR_REM;
        else if (pick < 85) it.operation = OP_REPORT;
        else if (pick < 99) it.operation = OP_MARK;
        else                it.operation = OP_UNUSED;
        it.port  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 2));
        it.queue = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0:       it.packet_bytes = 16'd0;
            1:       it.packet_bytes = 16'hFFFF;
            2, 3:    it.packet_bytes = 16'($urandom_range(0, 65535));
            default: it.packet_bytes = 16'($urandom_range(1, 3000));
        endcase
        it.random_fraction = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    task automatic random_phase(int beats);
        int burst;
        int gap;
        burst = 0;
        for (int i = 0; i < beats; i++) begin
            if (burst == 0 && $urandom_range(0, 29) == 0) burst = $urandom_range(10, 40);
            gap = (burst > 0) ? 0 : $urandom_range(0, 13);
            if (burst > 0) burst--;
            issue_command(packet_event(), gap);
            if ($urandom_range(0, 59) == 0) drain();
        end
        drain();
    endtask

    initial begin
        int low;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: empty buffer, zero thresholds
        issue_fields(OP_UNUSED, 4'd15, 3'd7, 16'hFFFF, 16'hFFFF);
        issue_fields(OP_ADMIT, 4'd0, 3'd0, 16'd0, 16'd0);
        issue_fields(OP_ADMIT, 4'd0, 3'd0, 16'd1, 16'd0);
        issue_fields(OP_MARK, 4'd0, 3'd1, 16'd0, 16'd0);
        drain();

        set_config(32'd100000, 32'd1000, 32'd5000, 32'd65536);
        // port over-committed: admission must reject, report wraps back
        issue_fields(OP_ING_ADD, 4'd2, 3'd3, 16'hFFFF, 16'd0);
        issue_fields(OP_ING_ADD, 4'd2, 3'd3, 16'hFFFF, 16'd0);
        issue_fields(OP_ADMIT, 4'd2, 3'd3, 16'd0, 16'd0);
        issue_fields(OP_REPORT, 4'd2, 3'd3, 16'd0, 16'd0);
        issue_fields(OP_ING_REM, 4'd2, 3'd3, 16'hFFFF, 16'd0);
        issue_fields(OP_ING_REM, 4'd2, 3'd4, 16'hFFFF, 16'd0);
        issue_fields(OP_ING_REM, 4'd2, 3'd3, 16'hFFFF, 16'd0);
        issue_fields(OP_REPORT, 4'd2, 3'd3, 16'd0, 16'd0);
        issue_fields(OP_ADMIT, 4'd2, 3'd3, 16'hFFFF, 16'd0);
        // queue zero is never marked
        issue_fields(OP_EGR_ADD, 4'd5, 3'd0, 16'd9000, 16'd0);
        issue_fields(OP_MARK, 4'd5, 3'd0, 16'd0, 16'd0);
        // linear region, then above high, then floor on removal
        issue_fields(OP_EGR_ADD, 4'd5, 3'd6, 16'd3000, 16'd0);
        issue_fields(OP_MARK, 4'd5, 3'd6, 16'd0, 16'd0);
        issue_fields(OP_MARK, 4'd5, 3'd6, 16'd0, 16'hFFFF);
        issue_fields(OP_EGR_ADD, 4'd5, 3'd6, 16'd5000, 16'd0);
        issue_fields(OP_MARK, 4'd5, 3'd6, 16'd0, 16'hFFFF);
        issue_fields(OP_EGR_REM, 4'd5, 3'd6, 16'hFFFF, 16'd0);
        issue_fields(OP_REPORT, 4'd5, 3'd6, 16'd0, 16'd0);
        issue_fields(OP_MARK, 4'd5, 3'd6, 16'd0, 16'd0);
        issue_fields(OP_EGR_ADD, 4'd5, 3'd6, 16'd1000, 16'd0);
        issue_fields(OP_MARK, 4'd5, 3'd6, 16'd0, 16'd0);
        drain();

        low = $urandom_range(0, 20000);
        set_config($urandom_range(50000, 300000), low, low + $urandom_range(1, 60000), 65536);
        random_phase(PHASE_BEATS);

        set_config(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(PHASE_BEATS);

        // equal thresholds, no buffer
        set_config(32'd0, 32'd0, 32'd0, 32'd0);
        random_phase(PHASE_BEATS);

        // crossed thresholds
        set_config($urandom_range(50000, 300000), $urandom_range(20000, 40000),
                   $urandom_range(0, 19999), $urandom_range(0, 65536));
        random_phase(PHASE_BEATS);

        // probability above one
        low = $urandom_range(0, 10000);
        set_config($urandom_range(100000, 500000), low, low + $urandom_range(1, 80000),
                   $urandom_range(65537, 131071));
        random_phase(PHASE_BEATS);

        set_config($urandom, $urandom, $urandom, $urandom);
        random_phase(PHASE_BEATS);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (ledger.pending() != 0)
            ledger.report("results never returned", 32'(ledger.pending()), 32'd0);
        if (ledger.errors == 0) begin
            $display("** switch_buffer_credit_accounting: PASSED **");
        end else begin
            $display("** switch_buffer_credit_accounting: FAILED **");
        end
        $finish;
    end

endmodule
